// File: rtl/nmq_pkg.sv
package nmq_pkg;

    localparam int NOTES_PER_OCT = 12;
    localparam int PITCH_W       = 20;
    localparam int E_W           = 32;   // Q16.16 note frequencies and working values
    localparam int Q_W           = 15;   // quotient bits out of the divider
    localparam int OCT_W         = 3;
    localparam int NOTE_W        = 4;
    localparam int DEV_W         = 16;

    localparam logic [63:0]    SEMI_Q30    = 64'd1137589835;   // 2^(1/12)
    localparam logic [63:0]    HALF_DN_Q32 = 64'd4172697914;   // 2^(-1/24)
    localparam logic [Q_W-1:0] ONE_Q14     = 15'd16384;

    typedef struct packed {
        logic start;      // latch the request, open the search window
        logic step;       // one binary search step
        logic load;       // fetch table entries around the found index
        logic setup;      // form numerator, denominator and flags
        logic div_step;   // one restoring division step
        logic out_load;   // write the result register
    } t_cmd;

    typedef struct packed {
        logic search_done;
    } t_stat;

    function automatic logic [63:0] semi_up(input logic [63:0] v);
        return (v * SEMI_Q30 + (64'd1 << 29)) >> 30;
    endfunction

    // Q16.16 frequency of table entry idx; octave 4 built from A3 by semitone steps
    function automatic logic [E_W-1:0] note_freq(input int ref_hz, input int idx);
        logic [63:0] v;
        logic [63:0] r;
        int          o;
        int          sh;
        v  = 64'(ref_hz) << 23;
        o  = idx / NOTES_PER_OCT;
        sh = 12 - (o & 7);
        for (int k = 0; k < 3 + (idx % NOTES_PER_OCT); k++) begin
            v = semi_up(v);
        end
        r = (v + (64'd1 << (sh - 1))) >> sh;
        return r[E_W-1:0];
    endfunction

    function automatic logic [E_W-1:0] note_mid(input int ref_hz, input int idx);
        logic [63:0] r;
        r = ({32'd0, note_freq(ref_hz, idx)} * HALF_DN_Q32 + (64'd1 << 31)) >> 32;
        return r[E_W-1:0];
    endfunction

endpackage

// File: rtl/nmq_ifs.sv
interface nmq_in_if;
    logic                             valid;
    logic                             ready;
    logic [nmq_pkg::PITCH_W-1:0]      pitch_hz;

    modport source (output valid, output pitch_hz, input ready);
    modport sink   (input valid, input pitch_hz, output ready);
endinterface

interface nmq_out_if;
    logic                             valid;
    logic                             ready;
    logic [nmq_pkg::OCT_W-1:0]        octave_index;
    logic [nmq_pkg::NOTE_W-1:0]       note_index;
    logic signed [nmq_pkg::DEV_W-1:0] deviation;

    modport source (output valid, output octave_index, output note_index, output deviation,
                    input ready);
    modport sink   (input valid, input octave_index, input note_index, input deviation,
                    output ready);
endinterface

// File: rtl/nmq_ctrl.sv
module nmq_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    input  nmq_pkg::t_stat  i_stat,
    output nmq_pkg::t_cmd   o_cmd
);

    localparam int CNT_W = $clog2(nmq_pkg::Q_W);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_LOAD,
        S_SETUP,
        S_DIV,
        S_DONE
    } t_state;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_out_valid, n_out_valid;
    logic             out_free;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd          = '0;
        o_cmd.start    = (r_state == S_IDLE) && i_in_valid;
        o_cmd.step     = (r_state == S_SEARCH) && !i_stat.search_done;
        o_cmd.load     = (r_state == S_LOAD);
        o_cmd.setup    = (r_state == S_SETUP);
        o_cmd.div_step = (r_state == S_DIV);
        o_cmd.out_load = (r_state == S_DONE) && out_free;
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid;
        if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_SEARCH;
                end
            end
            S_SEARCH: begin
                if (i_stat.search_done) begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                n_state = S_SETUP;
            end
            S_SETUP: begin
                n_cnt   = '0;
                n_state = S_DIV;
            end
            S_DIV: begin
                if (r_cnt == CNT_W'(nmq_pkg::Q_W - 1)) begin
                    n_state = S_DONE;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_DONE: begin
                // hold the result until the output register frees up
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) && i_in_valid |=> (r_state == S_SEARCH))
        else $error("accepted request did not start the search");

    a_div_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SETUP) |-> ##(nmq_pkg::Q_W + 1) (r_state == S_DONE))
        else $error("divider did not run the full step count");

    a_done_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) && r_out_valid && !i_out_ready |=> (r_state == S_DONE))
        else $error("result dropped while output register was full");

endmodule

// File: rtl/nmq_dp.sv
module nmq_dp #(
    parameter int REF_PITCH_HZ = 440,
    parameter int OCTAVES      = 5
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  nmq_pkg::t_cmd                    i_cmd,
    output nmq_pkg::t_stat                   o_stat,
    input  logic [nmq_pkg::PITCH_W-1:0]      i_pitch_hz,
    output logic [nmq_pkg::OCT_W-1:0]        o_octave_index,
    output logic [nmq_pkg::NOTE_W-1:0]       o_note_index,
    output logic signed [nmq_pkg::DEV_W-1:0] o_deviation
);

    localparam int L    = OCTAVES * nmq_pkg::NOTES_PER_OCT;
    localparam int IW   = $clog2(L);
    localparam int E_W  = nmq_pkg::E_W;
    localparam int Q_W  = nmq_pkg::Q_W;
    localparam int N_W  = E_W + 14;

    logic [E_W-1:0] c_note [L];
    logic [E_W-1:0] c_mid  [L];

    for (genvar g = 0; g < L; g++) begin : g_tab
        assign c_note[g] = nmq_pkg::note_freq(REF_PITCH_HZ, g);
        assign c_mid[g]  = nmq_pkg::note_mid(REF_PITCH_HZ, g);
    end

    function automatic logic [nmq_pkg::OCT_W+nmq_pkg::NOTE_W-1:0] split_idx(
        input logic [IW-1:0] idx);
        logic [nmq_pkg::OCT_W-1:0] oct;
        logic [IW-1:0]             base;
        logic [IW-1:0]             rem;
        oct  = '0;
        base = '0;
        for (int k = 1; k < OCTAVES; k++) begin
            if (idx >= IW'(k * nmq_pkg::NOTES_PER_OCT)) begin
                oct  = nmq_pkg::OCT_W'(k);
                base = IW'(k * nmq_pkg::NOTES_PER_OCT);
            end
        end
        rem = idx - base;
        return {oct, rem[nmq_pkg::NOTE_W-1:0]};
    endfunction

    logic [E_W-1:0]    r_f;
    logic [IW-1:0]     r_lo, r_hi;
    logic [E_W-1:0]    r_fi, r_m, r_fl;
    logic              r_first;
    logic [nmq_pkg::OCT_W+nmq_pkg::NOTE_W-1:0] r_pos_i, r_pos_p;
    logic [nmq_pkg::OCT_W+nmq_pkg::NOTE_W-1:0] r_pos;
    logic              r_neg, r_sat, r_zero;
    logic [E_W-1:0]    r_den, r_rem;
    logic [Q_W-1:0]    r_dvd;
    logic [nmq_pkg::OCT_W-1:0]        r_oct;
    logic [nmq_pkg::NOTE_W-1:0]       r_note;
    logic signed [nmq_pkg::DEV_W-1:0] r_dev;

    // search
    logic [IW:0]    mid_sum;
    logic [IW-1:0]  mid;
    logic [IW-1:0]  prev;

    assign mid_sum            = {1'b0, r_lo} + {1'b0, r_hi};
    assign mid                = mid_sum[IW:1];
    assign prev               = (r_lo == '0) ? '0 : r_lo - 1'b1;
    assign o_stat.search_done = (r_lo == r_hi);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lo <= '0;
            r_hi <= IW'(L - 1);
        end else if (i_cmd.start) begin
            r_lo <= '0;
            r_hi <= IW'(L - 1);
        end else if (i_cmd.step) begin
            if (c_note[mid] >= r_f) begin
                r_hi <= mid;
            end else begin
                r_lo <= mid + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_f <= E_W'({i_pitch_hz, 8'd0});
        end
        if (i_cmd.load) begin
            r_fi    <= c_note[r_lo];
            r_m     <= c_mid[r_lo];
            r_fl    <= c_note[prev];
            r_first <= (r_lo == '0);
            r_pos_i <= split_idx(r_lo);
            r_pos_p <= split_idx(prev);
        end
    end

    // numerator, denominator and special cases
    logic [E_W-1:0] num, den;
    logic           s_neg, s_sat, s_zero;
    logic [nmq_pkg::OCT_W+nmq_pkg::NOTE_W-1:0] s_pos;
    logic [N_W-1:0] dvd_full;

    always_comb begin
        num    = '0;
        den    = '0;
        s_neg  = 1'b0;
        s_sat  = 1'b0;
        s_zero = 1'b0;
        s_pos  = r_pos_i;
        if (r_first) begin
            num = r_fi - r_f;
            den = r_fi;
        end else if (r_f > r_m) begin
            if (r_f > r_fi) begin
                s_sat = 1'b1;
            end else begin
                s_neg = 1'b1;
                num   = r_fi - r_f;
                den   = (r_fi > r_m) ? r_fi - r_m : '0;
            end
        end else begin
            s_pos  = r_pos_p;
            s_zero = (r_f <= r_fl);
            num    = s_zero ? '0 : r_f - r_fl;
            den    = (r_m > r_fl) ? r_m - r_fl : '0;
        end
        if (!s_zero && ((den == '0) || (num >= den))) begin
            s_sat = 1'b1;
        end
        dvd_full = {num, 14'd0} + N_W'(den >> 1);
    end

    // restoring division: quotient bits shift into the low end of r_dvd
    logic [E_W:0] trial;
    logic         q_bit;

    assign trial = {r_rem, r_dvd[Q_W-1]};
    assign q_bit = (trial >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (i_cmd.setup) begin
            r_neg  <= s_neg;
            r_sat  <= s_sat;
            r_zero <= s_zero;
            r_pos  <= s_pos;
            r_den  <= den;
            r_rem  <= E_W'(dvd_full[N_W-1:Q_W]);
            r_dvd  <= dvd_full[Q_W-1:0];
        end else if (i_cmd.div_step) begin
            r_rem  <= q_bit ? E_W'(trial - {1'b0, r_den}) : trial[E_W-1:0];
            r_dvd  <= {r_dvd[Q_W-2:0], q_bit};
        end
    end

    logic [Q_W-1:0]            mag;
    logic signed [nmq_pkg::DEV_W-1:0] mag_s;

    always_comb begin
        if (r_zero) begin
            mag = '0;
        end else if (r_sat || (r_dvd > nmq_pkg::ONE_Q14)) begin
            mag = nmq_pkg::ONE_Q14;
        end else begin
            mag = r_dvd;
        end
        mag_s = signed'({1'b0, mag});
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_oct  <= r_pos[nmq_pkg::OCT_W+nmq_pkg::NOTE_W-1:nmq_pkg::NOTE_W];
            r_note <= r_pos[nmq_pkg::NOTE_W-1:0];
            r_dev  <= r_neg ? -mag_s : mag_s;
        end
    end

    assign o_octave_index = r_oct;
    assign o_note_index   = r_note;
    assign o_deviation    = r_dev;

    a_window_ordered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_lo <= r_hi) && (r_hi <= IW'(L - 1)))
        else $error("search window out of order or out of the table");

    a_dev_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_cmd.out_load) |->
            (r_dev <= 16'sd16384) && (r_dev >= -16'sd16384))
        else $error("deviation outside plus or minus one");

endmodule

// File: rtl/nearest_musical_note_quantizer.sv
// Nearest equal-tempered note for a pitch given in unsigned Q12.8 hertz. The note table
// (OCTAVES octaves from octave 0, tuned to A4 = REF_PITCH_HZ) is fixed at elaboration.
// Each request returns octave, semitone (0 = C) and a signed Q1.14 deviation in
// [-1.0, +1.0]. Each request runs a binary search over the table (5 or 6 steps for
// the default 60 entries, at most 7), then the 15-step restoring divider that forms
// the deviation. The input is taken only while no request is in work, but a finished
// result waiting in the output register does not block the next request.
module nearest_musical_note_quantizer #(
    parameter int REF_PITCH_HZ = 440,
    parameter int OCTAVES      = 5
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    nmq_in_if.sink     i_pitch,
    nmq_out_if.source  o_note
);

    nmq_pkg::t_cmd  cmd;
    nmq_pkg::t_stat stat;

    nmq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_pitch.valid),
        .o_in_ready  (i_pitch.ready),
        .o_out_valid (o_note.valid),
        .i_out_ready (o_note.ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    nmq_dp #(
        .REF_PITCH_HZ (REF_PITCH_HZ),
        .OCTAVES      (OCTAVES)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_pitch_hz     (i_pitch.pitch_hz),
        .o_octave_index (o_note.octave_index),
        .o_note_index   (o_note.note_index),
        .o_deviation    (o_note.deviation)
    );

endmodule

// File: verif/nmq_checker.sv
`timescale 1ns / 100ps

module nmq_checker #(
    parameter int REF_HZ = 440,
    parameter int OCT    = 5
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_end,
    nmq_in_if    i_pitch,
    nmq_out_if   i_note,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_checked
);
    import nmq_pkg::*;

    localparam int          NOTE_COUNT = OCT * NOTES_PER_OCT;
    localparam logic [63:0] UNITY      = 64'd16384;

    typedef struct packed {
        logic [OCT_W-1:0]  octave;
        logic [NOTE_W-1:0] semitone;
        logic [DEV_W-1:0]  deviation;
    } t_note_guess;

    logic [63:0] note_hz_q16  [NOTE_COUNT];
    logic [63:0] note_mid_q16 [NOTE_COUNT];

    t_note_guess expected_notes [$];
    int          fails         = 0;
    int          checked       = 0;
    bit          leftover_seen = 0;

    function automatic logic [63:0] raise_semitone(input logic [63:0] v);
        return (v * SEMI_Q30 + (64'd1 << 29)) >> 30;
    endfunction

    // magnitude in Q14, rounded half up, pinned to one
    function automatic logic [63:0] q14_fraction(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] q;
        if (den == 0 || num >= den) return UNITY;
        q = (num * UNITY + den / 2) / den;
        return (q > UNITY) ? UNITY : q;
    endfunction

    initial begin : build_notes
        logic [63:0] acc;
        logic [63:0] oct4 [NOTES_PER_OCT];
        int          sh;
        acc = 64'(REF_HZ) << 23;
        // A3 up to C4
        repeat (3) acc = raise_semitone(acc);
        for (int n = 0; n < NOTES_PER_OCT; n++) begin
            oct4[n] = acc;
            acc     = raise_semitone(acc);
        end
        for (int o = 0; o < OCT; o++) begin
            sh = 12 - (o & 7);
            for (int n = 0; n < NOTES_PER_OCT; n++) begin
                note_hz_q16[o*NOTES_PER_OCT+n]  = (oct4[n] + (64'd1 << (sh - 1))) >> sh;
                note_mid_q16[o*NOTES_PER_OCT+n] =
                    (note_hz_q16[o*NOTES_PER_OCT+n] * HALF_DN_Q32 + (64'd1 << 31)) >> 32;
            end
        end
    end

    function automatic t_note_guess nearest_note(input logic [PITCH_W-1:0] pitch);
        logic [63:0] f;
        logic [63:0] hi;
        logic [63:0] lo;
        logic [63:0] mid;
        logic [63:0] mag;
        int          i;
        int          near;
        bit          neg;
        t_note_guess g;
        f   = 64'(pitch) << 8;
        i   = 0;
        neg = 1'b0;
        while (i < NOTE_COUNT - 1 && f > note_hz_q16[i]) i++;
        if (i == 0) begin
            // below the lowest note
            near = 0;
            mag  = q14_fraction(note_hz_q16[0] - f, note_hz_q16[0]);
        end else begin
            hi  = note_hz_q16[i];
            mid = note_mid_q16[i];
            lo  = note_hz_q16[i-1];
            if (f > mid) begin
                near = i;
                if (f > hi) begin
                    mag = UNITY;    // above the top note
                end else begin
                    neg = 1'b1;
                    mag = q14_fraction(hi - f, (hi > mid) ? hi - mid : 64'd0);
                end
            end else begin
                near = i - 1;
                if (f <= lo) mag = 64'd0;
                else         mag = q14_fraction(f - lo, (mid > lo) ? mid - lo : 64'd0);
            end
        end
        g.octave    = OCT_W'(near / NOTES_PER_OCT);
        g.semitone  = NOTE_W'(near % NOTES_PER_OCT);
        g.deviation = neg ? DEV_W'(64'd0 - mag) : DEV_W'(mag);
        return g;
    endfunction

    task automatic report_mismatch(input string what);
        fails++;
        $display("[%0t] MISMATCH: %s", $realtime, what);
    endtask

    always @(posedge i_clk) begin : watch
        t_note_guess want;
        if (i_rst_n) begin
            if (i_note.valid && i_note.ready) begin
                if (expected_notes.size() == 0) begin
                    report_mismatch($sformatf("unexpected result octave %0d note %0d dev %0d",
                                              i_note.octave_index, i_note.note_index,
                                              $signed(i_note.deviation)));
                end else begin
                    want = expected_notes.pop_front();
                    checked++;
                    if (i_note.octave_index !== want.octave)
                        report_mismatch($sformatf("octave got %0d want %0d",
                                                  i_note.octave_index, want.octave));
                    if (i_note.note_index !== want.semitone)
                        report_mismatch($sformatf("note got %0d want %0d",
                                                  i_note.note_index, want.semitone));
                    if (i_note.deviation !== want.deviation)
                        report_mismatch($sformatf("deviation got %0d want %0d",
                                                  $signed(i_note.deviation),
                                                  $signed(want.deviation)));
                end
            end
            if (i_pitch.valid && i_pitch.ready)
                expected_notes.push_back(nearest_note(i_pitch.pitch_hz));
            if (i_end && !leftover_seen && expected_notes.size() != 0) begin
                leftover_seen = 1'b1;
                report_mismatch($sformatf("%0d results never arrived", expected_notes.size()));
            end
        end
        o_pending    <= expected_notes.size();
        o_checked    <= checked;
        o_fail_count <= fails;
    end

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import nmq_pkg::*;

    localparam int REF_HZ      = 440;
    localparam int OCT         = 5;
    localparam int NOTE_COUNT  = OCT * NOTES_PER_OCT;
    localparam int N_RANDOM    = 1900;
    localparam int QUIET_TAIL  = 300;
    localparam int STALL_LIMIT = 3000;
    localparam int SETTLE      = 40;

    logic i_clk;
    logic i_rst_n;
    logic run_end;
    logic idle_en;
    int   fail_count;
    int   pending;
    int   checked;
    int   sent        = 0;
    int   hold_cycles = 0;
    int   quiet       = 0;

    nmq_in_if  pitch_if ();
    nmq_out_if note_if ();

    nearest_musical_note_quantizer #(
        .REF_PITCH_HZ (REF_HZ),
        .OCTAVES      (OCT)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pitch (pitch_if),
        .o_note  (note_if)
    );

    nmq_checker #(
        .REF_HZ (REF_HZ),
        .OCT    (OCT)
    ) chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_end        (run_end),
        .i_pitch      (pitch_if),
        .i_note       (note_if),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    initial i_clk = 1'b0;
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // result side: stall in bursts while idling is enabled
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            note_if.ready <= 1'b0;
            hold_cycles   <= 0;
        end else if (hold_cycles > 0) begin
            note_if.ready <= 1'b0;
            hold_cycles   <= hold_cycles - 1;
        end else if (idle_en && $urandom_range(0, 5) == 0) begin
            note_if.ready <= 1'b0;
            hold_cycles   <= $urandom_range(0, 16);
        end else begin
            note_if.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if ((pitch_if.valid && pitch_if.ready) || (note_if.valid && note_if.ready)) begin
            quiet <= 0;
        end else begin
            quiet <= quiet + 1;
            if (quiet >= STALL_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // keep valid high across back-to-back requests; drop it only for a gap
    task automatic send_pitch(input logic [PITCH_W-1:0] p);
        if (idle_en && $urandom_range(0, 3) == 0) begin
            pitch_if.valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
        pitch_if.valid    <= 1'b1;
        pitch_if.pitch_hz <= p;
        @(posedge i_clk);
        while (!pitch_if.ready) @(posedge i_clk);
        sent++;
    endtask

    task automatic drain_notes();
        pitch_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    initial begin : stimulus
        logic [PITCH_W-1:0] directed [$];
        logic [63:0]        base;
        logic [63:0]        top_hz;
        int                 k;
        int                 span;
        int                 pick;
        longint             p;
        int                 probe [4];

        i_rst_n           = 1'b0;
        run_end           = 1'b0;
        idle_en           = 1'b1;
        pitch_if.valid    = 1'b0;
        pitch_if.pitch_hz = '0;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // zero, one, all ones, alternating bits, A4
        directed = '{20'h00000, 20'h00001, 20'hFFFFF, 20'h55555, 20'hAAAAA, 20'(REF_HZ * 256)};
        probe    = '{0, 1, NOTE_COUNT / 2, NOTE_COUNT - 1};
        for (int j = 0; j < 4; j++) begin
            k = probe[j];
            directed.push_back(20'(chk.note_hz_q16[k] >> 8));
            directed.push_back(20'((chk.note_hz_q16[k] >> 8) + 1));
            directed.push_back(20'(chk.note_mid_q16[k] >> 8));
            directed.push_back(20'((chk.note_mid_q16[k] >> 8) + 1));
        end
        directed.push_back(20'((chk.note_hz_q16[0] >> 8) - 1));
        foreach (directed[j]) send_pitch(directed[j]);

        top_hz = (chk.note_hz_q16[NOTE_COUNT-1] >> 8) + 512;
        for (int n = 0; n < N_RANDOM; n++) begin
            idle_en = (n < N_RANDOM - QUIET_TAIL) && ((n % 400) < 300);
            if (n == 700 || n == 1400) drain_notes();
            pick = $urandom_range(0, 9);
            k    = $urandom_range(0, NOTE_COUNT - 1);
            if (pick < 6) begin
                // around a note or a midpoint
                base = (pick < 4) ? chk.note_hz_q16[k] >> 8 : chk.note_mid_q16[k] >> 8;
                span = int'(base / 16) + 2;
                p    = longint'(base) - span + $urandom_range(0, 2 * span);
                if (p < 0) p = 0;
            end else if (pick < 9) begin
                p = $urandom_range(0, int'(top_hz));
            end else begin
                p = $urandom_range(0, (1 << PITCH_W) - 1);
            end
            send_pitch(20'(p));
        end

        drain_notes();
        repeat (SETTLE) @(posedge i_clk);
        run_end <= 1'b1;
        @(posedge i_clk);
        @(posedge i_clk);

        $display("Sent %0d pitches: edge values, notes and midpoints, near-note and wide random",
                 sent);
        $display("Compared %0d results on octave, semitone and deviation", checked);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// File: nearest_musical_note_quantizer.f
rtl/nmq_pkg.sv
rtl/nmq_ifs.sv
rtl/nmq_ctrl.sv
rtl/nmq_dp.sv
rtl/nearest_musical_note_quantizer.sv
verif/nmq_checker.sv
verif/tb_top.sv
